// ===== design/iswbc_pkg.sv =====
// Shared types and constants of the static-window gyro bias calibrator.
`default_nettype none
package iswbc_pkg;

  localparam int WINDOW_MAX_DEF = 16384;
  localparam int BIAS_W         = 20;
  localparam int BIAS_MAX       = 524287;
  localparam int BIAS_MIN       = -524288;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 15;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_WINDOW_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_STD_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_STD_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_BIAS_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_LEVEL    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_TOL      = 3'd6;

  localparam logic [13:0] RST_FIRST_WINDOW_LEN = 14'd1000;
  localparam logic [14:0] RST_WINDOW_LEN       = 15'd10000;
  localparam logic [14:0] RST_ACC_STD_LIMIT    = 15'd64;
  localparam logic [14:0] RST_GYRO_STD_LIMIT   = 15'd16;
  localparam logic [14:0] RST_GYRO_BIAS_LIMIT  = 15'd64;
  localparam logic [14:0] RST_GRAVITY_LEVEL    = 15'd2048;
  localparam logic [14:0] RST_GRAVITY_TOL      = 15'd128;

  typedef struct packed {
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic               calib_active;
  } in_t;

  typedef struct packed {
    logic                     is_static;
    logic signed [BIAS_W-1:0] bias_x;
    logic signed [BIAS_W-1:0] bias_y;
    logic signed [BIAS_W-1:0] bias_z;
    logic                     was_first_window;
  } out_t;

  typedef struct packed {
    logic add;
    logic clr;
  } lane_ctl_t;

endpackage
`default_nettype wire

// ===== design/iswbc_lane.sv =====
// One axis lane: running sum and sum of squares, and the window variance test.
`default_nettype none
module iswbc_lane import iswbc_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire lane_ctl_t                              ctl,
  input  wire logic signed [15:0]                     x,
  input  wire logic [$clog2(WINDOW_MAX+1)-1:0]        n,
  input  wire logic [14:0]                            limit,
  output logic [$clog2(WINDOW_MAX+1)+14:0]            mag,
  output logic                                        neg,
  output logic [2*($clog2(WINDOW_MAX+1)+15)-1:0]      aa,
  output logic                                        ok
);
  localparam int CNT_W = $clog2(WINDOW_MAX+1);
  localparam int SUM_W = CNT_W + 16;
  localparam int MAG_W = SUM_W - 1;
  localparam int SQ_W  = CNT_W + 30;
  localparam int NUM_W = CNT_W + SQ_W;
  localparam int LIM_W = CNT_W + 15;
  localparam int AA_W  = 2 * MAG_W;
  localparam int HI_W  = SQ_W - 30;

  logic signed [SUM_W-1:0] sum;
  logic [SQ_W-1:0]         sq_sum;
  logic signed [31:0]      x_sq;
  logic signed [SUM_W-1:0] sum_neg;

  logic [CNT_W+29:0]       p_lo;
  logic [CNT_W+HI_W-1:0]   p_hi;
  logic [LIM_W-1:0]        lim;
  logic [NUM_W-1:0]        nsq;
  logic [AA_W-1:0]         aa_d;
  logic [2*LIM_W-1:0]      lim2;

  assign x_sq    = x * x;
  assign sum_neg = -sum;
  assign neg     = sum[SUM_W-1];
  assign mag     = neg ? sum_neg[MAG_W-1:0] : sum[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      sum    <= '0;
      sq_sum <= '0;
    end else if (ctl.add) begin
      sum    <= sum + {{(SUM_W-16){x[15]}}, x};
      sq_sum <= sq_sum + {{(SQ_W-31){1'b0}}, x_sq[30:0]};
    end
  end

  // three-stage test: n*sq - s^2 < (limit*n)^2, n*sq split in two products
  always_ff @(posedge clk) begin
    p_lo <= n * sq_sum[29:0];
    p_hi <= n * sq_sum[SQ_W-1:30];
    aa   <= mag * mag;
    lim  <= LIM_W'(limit * n);
    nsq  <= (NUM_W'(p_hi) << 30) + NUM_W'(p_lo);
    aa_d <= aa;
    lim2 <= lim * lim;
    ok   <= (NUM_W'(nsq - NUM_W'(aa_d))) < NUM_W'(lim2);
  end

endmodule
`default_nettype wire

// ===== design/iswbc_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module iswbc_div import iswbc_pkg::*; #(
  parameter int DVD_W = 31,
  parameter int DVS_W = 15
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0]      quo,
  output logic                  done
);
  localparam int CW = $clog2(DVD_W+1);

  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DVS_W-1:0] rem;
  logic [DVS_W:0]   rem_sh;
  logic             take;

  assign rem_sh = {rem, quo[DVD_W-1]};
  assign take   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DVD_W);
      end else if (busy) begin
        cnt  <= cnt - CW'(1);
        busy <= cnt != CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      rem <= take ? DVS_W'(rem_sh - {1'b0, divisor}) : rem_sh[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], take};
    end
  end

endmodule
`default_nettype wire

// ===== design/iswbc_merge.sv =====
// Merge stage: gyro bias test, gravity norm test, and the lane variance results.
`default_nettype none
module iswbc_merge import iswbc_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  wire logic                                           clk,
  input  wire logic [2:0][2*($clog2(WINDOW_MAX+1)+15)-1:0]    acc_aa,
  input  wire logic [2:0][$clog2(WINDOW_MAX+1)+14:0]          gyro_mag,
  input  wire logic [5:0]                                     lane_ok,
  input  wire logic [$clog2(WINDOW_MAX+1)-1:0]                n,
  input  wire logic [14:0]                                    gyro_bias_limit,
  input  wire logic [14:0]                                    gravity_level,
  input  wire logic [14:0]                                    gravity_tol,
  output logic                                                pass
);
  localparam int CNT_W = $clog2(WINDOW_MAX+1);
  localparam int MAG_W = CNT_W + 15;
  localparam int AA_W  = 2 * MAG_W;
  localparam int S_W   = AA_W + 2;
  localparam int HI_W  = CNT_W + 16;
  localparam int LO_W  = CNT_W + 15;

  logic [LO_W-1:0]   bl;
  logic [HI_W-1:0]   hi;
  logic [LO_W-1:0]   lo;
  logic              lo_use;
  logic              lo_use_d;
  logic [S_W-1:0]    s;
  logic [2*HI_W-1:0] hi2;
  logic [2*LO_W-1:0] lo2;
  logic              bias_ok;
  logic              grav_ok;
  logic [15:0]       g_hi;

  assign g_hi = {1'b0, gravity_level} + {1'b0, gravity_tol};

  always_ff @(posedge clk) begin
    bl       <= LO_W'(gyro_bias_limit * n);
    hi       <= HI_W'(g_hi * n);
    lo       <= LO_W'((gravity_level - gravity_tol) * n);
    lo_use   <= gravity_level >= gravity_tol;
    s        <= S_W'(acc_aa[0]) + S_W'(acc_aa[1]) + S_W'(acc_aa[2]);
    hi2      <= hi * hi;
    lo2      <= lo * lo;
    lo_use_d <= lo_use;
    bias_ok  <= (gyro_mag[0] < bl) && (gyro_mag[1] < bl) && (gyro_mag[2] < bl);
    grav_ok  <= (S_W'(s) < S_W'(hi2)) && (!lo_use_d || (S_W'(s) > S_W'(lo2)));
  end

  assign pass = grav_ok && bias_ok && (&lane_ok);

endmodule
`default_nettype wire

// ===== design/imu_static_window_bias_calibrator_top.sv =====
// Top level of the static-window gyro bias calibrator.
//
// Input channel (in_valid / in_stall / in_data): one IMU sample per
// transaction; calib_active low discards the sample. Config channel
// (cfg_valid / cfg_ready / cfg_index / cfg_data) writes one register per
// transaction, always ready; write only while the block is idle.
// Output channel (out_valid / out_stall / out_data): one transaction per
// closed window.
// The block takes one sample per cycle while it is idle, between window
// closes. A closing sample holds in_stall high through the six variance
// lanes and the merge stage, the 31 steps of the gyro mean divider, the
// divider's done flag, and the load of the output register. out_valid rises
// with that load, in the cycle in which in_stall drops.
// If the receiver stalls, the result stays in the output register and input
// keeps flowing until another window closes; that close waits for the
// register to drain.
// Reset (rst, synchronous) restores register defaults, clears sums, counts,
// bias and the first-window flag, and drops out_valid.
`default_nettype none
module imu_static_window_bias_calibrator_top import iswbc_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_t                       out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int CNT_W    = $clog2(WINDOW_MAX+1);
  localparam int MAG_W    = CNT_W + 15;
  localparam int AA_W     = 2 * MAG_W;
  localparam int DVD_W    = MAG_W + 1;
  localparam int ADD_W    = DVD_W + 2;
  localparam int EVAL_LAT = 4;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam logic signed [ADD_W-1:0] B_MAX = ADD_W'(BIAS_MAX);
  localparam logic signed [ADD_W-1:0] B_MIN = ADD_W'(BIAS_MIN);

  logic [13:0] first_window_len;
  logic [14:0] window_len, acc_std_limit, gyro_std_limit, gyro_bias_limit;
  logic [14:0] gravity_level, gravity_tol;

  logic [1:0]       state;
  logic [2:0]       ecnt;
  logic [CNT_W-1:0] count;
  logic             first_done, prev_active, pass_r, was_first;
  logic [2:0][BIAS_W-1:0] bias;

  logic             accept, active, entering, leaving, fd_eff, close, load;
  logic [CNT_W-1:0] cnt_new, fw_c, wl_c;
  logic [31:0]      fw32, wl32;
  lane_ctl_t        lctl;

  logic [5:0][15:0]      lane_x;
  logic [5:0][14:0]      lane_lim;
  logic [5:0][MAG_W-1:0] lane_mag;
  logic [5:0]            lane_neg;
  logic [5:0][AA_W-1:0]  lane_aa;
  logic [5:0]            lane_ok;
  logic                  pass;
  logic [2:0][DVD_W-1:0] quo;
  logic [2:0]            div_done;
  logic                  div_start;
  logic [2:0][BIAS_W-1:0] bias_next;

  assign cfg_ready = 1'b1;
  assign in_stall  = state != S_IDLE;
  assign accept    = in_valid && !in_stall;
  assign active    = in_data.calib_active;
  assign entering  = active && !prev_active;
  assign leaving   = !active && prev_active;
  assign fd_eff    = first_done && !entering;
  assign cnt_new   = count + CNT_W'(1);

  always_comb begin
    fw32 = 32'(first_window_len);
    if (fw32 < 32'd1) fw32 = 32'd1;
    if (fw32 > 32'(WINDOW_MAX - 1)) fw32 = 32'(WINDOW_MAX - 1);
    wl32 = 32'(window_len);
    if (wl32 < 32'd2) wl32 = 32'd2;
    if (wl32 > 32'(WINDOW_MAX)) wl32 = 32'(WINDOW_MAX);
    fw_c = CNT_W'(fw32);
    wl_c = CNT_W'(wl32);
  end

  assign close = fd_eff ? (cnt_new >= wl_c) : (cnt_new > fw_c);
  assign load  = (state == S_FIN) && (!out_valid || !out_stall);
  assign lctl.add = accept && active;
  assign lctl.clr = (accept && leaving) || load;
  assign div_start = (state == S_EVAL) && (ecnt == 3'(EVAL_LAT));

  assign lane_x   = {in_data.gyro_z, in_data.gyro_y, in_data.gyro_x,
                     in_data.acc_z, in_data.acc_y, in_data.acc_x};
  assign lane_lim = {gyro_std_limit, gyro_std_limit, gyro_std_limit,
                     acc_std_limit, acc_std_limit, acc_std_limit};

  for (genvar i = 0; i < 6; i++) begin : g_lane
    iswbc_lane #(.WINDOW_MAX(WINDOW_MAX)) u_lane (
      .clk   (clk),
      .rst   (rst),
      .ctl   (lctl),
      .x     (lane_x[i]),
      .n     (count),
      .limit (lane_lim[i]),
      .mag   (lane_mag[i]),
      .neg   (lane_neg[i]),
      .aa    (lane_aa[i]),
      .ok    (lane_ok[i])
    );
  end

  iswbc_merge #(.WINDOW_MAX(WINDOW_MAX)) u_merge (
    .clk             (clk),
    .acc_aa          (lane_aa[2:0]),
    .gyro_mag        (lane_mag[5:3]),
    .lane_ok         (lane_ok),
    .n               (count),
    .gyro_bias_limit (gyro_bias_limit),
    .gravity_level   (gravity_level),
    .gravity_tol     (gravity_tol),
    .pass            (pass)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    logic signed [ADD_W-1:0] q_s;
    logic signed [ADD_W-1:0] b_sum;

    iswbc_div #(.DVD_W(DVD_W), .DVS_W(CNT_W)) u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (div_start),
      .dividend ({1'b0, lane_mag[i+3]} + DVD_W'(count >> 1)),
      .divisor  (count),
      .quo      (quo[i]),
      .done     (div_done[i])
    );

    // rounded mean added to the bias, saturated to 20 bits
    always_comb begin
      q_s   = lane_neg[i+3] ? -{2'b00, quo[i]} : {2'b00, quo[i]};
      b_sum = {{(ADD_W-BIAS_W){bias[i][BIAS_W-1]}}, bias[i]} + q_s;
      if (b_sum > B_MAX)      bias_next[i] = BIAS_W'(B_MAX);
      else if (b_sum < B_MIN) bias_next[i] = BIAS_W'(B_MIN);
      else                    bias_next[i] = b_sum[BIAS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_window_len <= RST_FIRST_WINDOW_LEN;
      window_len       <= RST_WINDOW_LEN;
      acc_std_limit    <= RST_ACC_STD_LIMIT;
      gyro_std_limit   <= RST_GYRO_STD_LIMIT;
      gyro_bias_limit  <= RST_GYRO_BIAS_LIMIT;
      gravity_level    <= RST_GRAVITY_LEVEL;
      gravity_tol      <= RST_GRAVITY_TOL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FIRST_WINDOW_LEN: first_window_len <= cfg_data[13:0];
        REG_WINDOW_LEN:       window_len       <= cfg_data;
        REG_ACC_STD_LIMIT:    acc_std_limit    <= cfg_data;
        REG_GYRO_STD_LIMIT:   gyro_std_limit   <= cfg_data;
        REG_GYRO_BIAS_LIMIT:  gyro_bias_limit  <= cfg_data;
        REG_GRAVITY_LEVEL:    gravity_level    <= cfg_data;
        REG_GRAVITY_TOL:      gravity_tol      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ecnt        <= '0;
      count       <= '0;
      first_done  <= 1'b0;
      prev_active <= 1'b0;
      bias        <= '0;
      out_valid   <= 1'b0;
      pass_r      <= 1'b0;
      was_first   <= 1'b0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            prev_active <= active;
            if (entering) first_done <= 1'b0;
            if (leaving) count <= '0;
            else if (active) count <= cnt_new;
            if (active && close) begin
              state     <= S_EVAL;
              ecnt      <= '0;
              was_first <= !fd_eff;
            end
          end
        end
        S_EVAL: begin
          ecnt <= ecnt + 3'd1;
          if (div_start) begin
            pass_r <= pass;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done[0]) state <= S_FIN;
        end
        S_FIN: begin
          if (load) begin
            if (pass_r) begin
              bias       <= bias_next;
              first_done <= 1'b1;
            end
            count <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.is_static        <= pass_r;
      out_data.bias_x           <= pass_r ? bias_next[0] : bias[0];
      out_data.bias_y           <= pass_r ? bias_next[1] : bias[1];
      out_data.bias_z           <= pass_r ? bias_next[2] : bias[2];
      out_data.was_first_window <= was_first;
    end
  end

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (count >= CNT_W'(2)))
    else $error("window closed with fewer than two samples");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(WINDOW_MAX))
    else $error("sample count beyond window maximum");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> (out_valid && state == S_IDLE && count == '0))
    else $error("window close did not publish result");

  a_leave_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && leaving) |=> (count == '0))
    else $error("leaving calibration did not clear window");

  a_div_after_eval: assert property (@(posedge clk) disable iff (rst)
    div_start |=> (state == S_DIV))
    else $error("divider start without divide phase");

endmodule
`default_nettype wire
